@@ rtl/qte_pkg.sv @@
`default_nettype none
package qte_pkg;

    // Widths of the rotation-matrix terms and the angle datapath
    localparam int TERM_W         = 34;
    localparam int ACC_FRAC       = 30;
    localparam int ACC_W          = 33;
    localparam int PRESCALE_SHIFT = 20;
    localparam int CORDIC_W       = TERM_W + PRESCALE_SHIFT + 2;
    localparam int ROOT_W         = 31;
    localparam int SQ_W           = 2 * ROOT_W;
    localparam int Q_W            = 16;
    localparam int PROD_W         = 2 * Q_W;

    localparam logic signed [ACC_W-1:0] PI_Q30      = 33'sd3373259426;
    localparam logic signed [ACC_W-1:0] HALF_PI_Q30 = 33'sd1686629713;

    // Rotation sequence codes
    typedef enum logic [3:0] {
        SEQ_ZYX = 4'd0,
        SEQ_ZYZ = 4'd1,
        SEQ_ZXY = 4'd2,
        SEQ_ZXZ = 4'd3,
        SEQ_YXZ = 4'd4,
        SEQ_YXY = 4'd5,
        SEQ_YZX = 4'd6,
        SEQ_YZY = 4'd7,
        SEQ_XYZ = 4'd8,
        SEQ_XYX = 4'd9,
        SEQ_XZY = 4'd10,
        SEQ_XZX = 4'd11
    } seq_t;

    typedef logic signed [TERM_W-1:0] term_t;

    typedef struct packed {
        logic three;
        logic seq_ok;
        logic clamped;
    } flags_t;

    typedef struct packed {
        term_t                     r0;
        term_t                     r1;
        term_t                     r3;
        term_t                     r4;
        logic signed [ACC_FRAC+1:0] a;
        flags_t                    flags;
    } side_t;

    // atan(2^-i) in Q30
    localparam logic [31:0] ATAN_TAB [0:31] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
        32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
        32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
        32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256, 32'd128,
        32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd1
    };

endpackage
`default_nettype wire

@@ rtl/quaternion_to_euler_angles_core.sv @@
`default_nettype none
// Pipeline stages from input beat to output beat: 3 term stages, 32 square-root stages,
// CORDIC_STAGES + 2 CORDIC stages, 1 output stage.
// Throughput: one quaternion per cycle; the whole pipeline advances as one and
// stalls only when the output register holds a beat that is not taken.
// Reset (rst_n, asynchronous, active low) clears all valid bits and sets the
// rotation sequence register to ZYX.
module quaternion_to_euler_angles_core #(
    parameter int CORDIC_STAGES   = 16,
    parameter int INPUT_FRAC_BITS = 15,
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_wr_en,
    input  wire  [3:0]  cfg_wr_data,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [63:0] s_tdata,   // quat_x[15:0], quat_y[31:16], quat_z[47:32], quat_w[63:48]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [47:0] m_tdata,   // angle_first[15:0], angle_second[31:16], angle_third[47:32]
    output logic [0:0]  m_tuser    // arg_clamped[0]
);

    localparam int AW    = qte_pkg::ACC_W;
    localparam int RSH   = qte_pkg::ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int LAT   = CORDIC_STAGES + 38;
    localparam int CNT_W = $clog2(LAT + 2);
    localparam logic signed [AW:0] HALF_LSB = (AW+1)'(1) <<< (RSH - 1);
    localparam logic signed [AW:0] SAT_HI   = (AW+1)'(32767);
    localparam logic signed [AW:0] SAT_LO   = -(AW+1)'(32768);

    function automatic logic [15:0] to_angle(input logic signed [AW-1:0] z);
        logic signed [AW:0] t;
        t = ($signed({z[AW-1], z}) + HALF_LSB) >>> RSH;
        if (t > SAT_HI)
        begin
            t = SAT_HI;
        end
        if (t < SAT_LO)
        begin
            t = SAT_LO;
        end
        return t[15:0];
    endfunction

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // sequence register
    logic [3:0] seq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg <= qte_pkg::SEQ_ZYX;
        end
        else if (cfg_wr_en)
        begin
            seq_reg <= cfg_wr_data;
        end
    end

    // matrix terms and middle argument
    logic                       t_valid;
    logic [qte_pkg::ROOT_W-1:0] t_m;
    qte_pkg::side_t             t_side;

    qte_terms #(
        .INPUT_FRAC_BITS(INPUT_FRAC_BITS)
    ) u_terms (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .quat_x    (s_tdata[15:0]),
        .quat_y    (s_tdata[31:16]),
        .quat_z    (s_tdata[47:32]),
        .quat_w    (s_tdata[63:48]),
        .seq       (seq_reg),
        .out_valid (t_valid),
        .out_m     (t_m),
        .out_side  (t_side)
    );

    // cosine-side operand sqrt(1 - m^2)
    logic                       q_valid;
    logic [qte_pkg::ROOT_W-1:0] q_root;
    qte_pkg::side_t             q_side;

    qte_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (t_valid),
        .in_m      (t_m),
        .in_side   (t_side),
        .out_valid (q_valid),
        .out_root  (q_root),
        .out_side  (q_side)
    );

    // route operands to the three angle units
    qte_pkg::term_t c_term, a_term;
    qte_pkg::term_t y1, x1, y2, x2, y3, x3;

    always_comb
    begin
        c_term = {{(qte_pkg::TERM_W-qte_pkg::ROOT_W){1'b0}}, q_root};
        a_term = {{(qte_pkg::TERM_W-qte_pkg::ACC_FRAC-2){q_side.a[qte_pkg::ACC_FRAC+1]}},
                  q_side.a};
        if (q_side.flags.three)
        begin
            y1 = q_side.r3; x1 = q_side.r4;
            y2 = a_term;    x2 = c_term;
            y3 = q_side.r0; x3 = q_side.r1;
        end
        else
        begin
            y1 = q_side.r0; x1 = q_side.r1;
            y2 = c_term;    x2 = a_term;
            y3 = q_side.r3; x3 = q_side.r4;
        end
    end

    logic                 c_valid;
    logic signed [AW-1:0] z1, z2, z3;
    qte_pkg::flags_t      c_flags;

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_first (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(q_valid),
        .in_y(y1), .in_x(x1), .in_sb('0),
        .out_valid(), .out_z(z1), .out_sb()
    );

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_second (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(q_valid),
        .in_y(y2), .in_x(x2), .in_sb(q_side.flags),
        .out_valid(c_valid), .out_z(z2), .out_sb(c_flags)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_third (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(q_valid),
        .in_y(y3), .in_x(x3), .in_sb('0),
        .out_valid(), .out_z(z3), .out_sb()
    );

    // output register: round to the angle format, zero for unused codes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid <= 1'b0;
        end
        else if (en)
        begin
            m_tvalid <= c_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tdata[15:0]  <= c_flags.seq_ok ? to_angle(z1) : 16'd0;
            m_tdata[31:16] <= c_flags.seq_ok ? to_angle(z2) : 16'd0;
            m_tdata[47:32] <= c_flags.seq_ok ? to_angle(z3) : 16'd0;
            m_tuser[0]     <= c_flags.seq_ok & c_flags.clamped;
        end
    end

    // beats in flight, for checking
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg + CNT_W'(s_tvalid && s_tready) - CNT_W'(m_tvalid && m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while output is stalled");

    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(LAT))
        else $error("more beats in flight than pipeline stages");

    a_empty_no_output: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> !m_tvalid)
        else $error("output beat with nothing in flight");

endmodule
`default_nettype wire

@@ rtl/qte_terms.sv @@
`default_nettype none
module qte_terms #(
    parameter int INPUT_FRAC_BITS = 15
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  en,
    input  wire                                  in_valid,
    input  wire logic signed [qte_pkg::Q_W-1:0]  quat_x,
    input  wire logic signed [qte_pkg::Q_W-1:0]  quat_y,
    input  wire logic signed [qte_pkg::Q_W-1:0]  quat_z,
    input  wire logic signed [qte_pkg::Q_W-1:0]  quat_w,
    input  wire logic [3:0]                      seq,
    output logic                                 out_valid,
    output logic [qte_pkg::ROOT_W-1:0]           out_m,
    output qte_pkg::side_t                       out_side
);

    localparam int FB2 = 2 * INPUT_FRAC_BITS;
    localparam int SHR = (FB2 >= qte_pkg::ACC_FRAC) ? FB2 - qte_pkg::ACC_FRAC : 0;
    localparam int SHL = (FB2 >= qte_pkg::ACC_FRAC) ? 0 : qte_pkg::ACC_FRAC - FB2;
    localparam logic signed [63:0] ONE     = 64'sd1 <<< FB2;
    localparam logic        [63:0] ONE_Q30 = 64'd1 << qte_pkg::ACC_FRAC;

    function automatic qte_pkg::term_t ext(input logic signed [qte_pkg::PROD_W-1:0] p);
        return {{(qte_pkg::TERM_W-qte_pkg::PROD_W){p[qte_pkg::PROD_W-1]}}, p};
    endfunction

    // stage 1: component products
    logic signed [qte_pkg::PROD_W-1:0] xx_reg, yy_reg, zz_reg, ww_reg;
    logic signed [qte_pkg::PROD_W-1:0] xy_reg, wz_reg, xz_reg, wy_reg, yz_reg, wx_reg;
    logic [3:0] seq1_reg;
    logic       v1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg   <= quat_x * quat_x;
            yy_reg   <= quat_y * quat_y;
            zz_reg   <= quat_z * quat_z;
            ww_reg   <= quat_w * quat_w;
            xy_reg   <= quat_x * quat_y;
            wz_reg   <= quat_w * quat_z;
            xz_reg   <= quat_x * quat_z;
            wy_reg   <= quat_w * quat_y;
            yz_reg   <= quat_y * quat_z;
            wx_reg   <= quat_w * quat_x;
            seq1_reg <= seq;
        end
    end

    // stage 2: matrix terms for the chosen sequence
    qte_pkg::term_t xyp2, xym2, xzp2, xzm2, yzp2, yzm2, da, db, dc;
    qte_pkg::term_t r0_next, r1_next, r2_next, r3_next, r4_next;
    logic three_next, ok_next;

    always_comb
    begin
        xyp2 = (ext(xy_reg) + ext(wz_reg)) <<< 1;
        xym2 = (ext(xy_reg) - ext(wz_reg)) <<< 1;
        xzp2 = (ext(xz_reg) + ext(wy_reg)) <<< 1;
        xzm2 = (ext(xz_reg) - ext(wy_reg)) <<< 1;
        yzp2 = (ext(yz_reg) + ext(wx_reg)) <<< 1;
        yzm2 = (ext(yz_reg) - ext(wx_reg)) <<< 1;
        da   = ext(ww_reg) + ext(xx_reg) - ext(yy_reg) - ext(zz_reg);
        db   = ext(ww_reg) - ext(xx_reg) + ext(yy_reg) - ext(zz_reg);
        dc   = ext(ww_reg) - ext(xx_reg) - ext(yy_reg) + ext(zz_reg);
        three_next = 1'b0;
        ok_next    = 1'b1;
        r0_next = '0; r1_next = '0; r2_next = '0; r3_next = '0; r4_next = '0;
        case (qte_pkg::seq_t'(seq1_reg))
            qte_pkg::SEQ_ZYX:
            begin
                three_next = 1'b1;
                r0_next = xyp2; r1_next = da; r2_next = -xzm2; r3_next = yzp2; r4_next = dc;
            end
            qte_pkg::SEQ_ZYZ:
            begin
                r0_next = yzm2; r1_next = xzp2; r2_next = dc; r3_next = yzp2; r4_next = -xzm2;
            end
            qte_pkg::SEQ_ZXY:
            begin
                three_next = 1'b1;
                r0_next = -xym2; r1_next = db; r2_next = yzp2; r3_next = -xzm2; r4_next = dc;
            end
            qte_pkg::SEQ_ZXZ:
            begin
                r0_next = xzp2; r1_next = -yzm2; r2_next = dc; r3_next = xzm2; r4_next = yzp2;
            end
            qte_pkg::SEQ_YXZ:
            begin
                three_next = 1'b1;
                r0_next = xzp2; r1_next = dc; r2_next = -yzm2; r3_next = xyp2; r4_next = db;
            end
            qte_pkg::SEQ_YXY:
            begin
                r0_next = xym2; r1_next = yzp2; r2_next = db; r3_next = xyp2; r4_next = -yzm2;
            end
            qte_pkg::SEQ_YZX:
            begin
                three_next = 1'b1;
                r0_next = -xzm2; r1_next = da; r2_next = xyp2; r3_next = -yzm2; r4_next = db;
            end
            qte_pkg::SEQ_YZY:
            begin
                r0_next = yzp2; r1_next = -xym2; r2_next = db; r3_next = yzm2; r4_next = xyp2;
            end
            qte_pkg::SEQ_XYZ:
            begin
                three_next = 1'b1;
                r0_next = -yzm2; r1_next = dc; r2_next = xzp2; r3_next = -xym2; r4_next = da;
            end
            qte_pkg::SEQ_XYX:
            begin
                r0_next = xyp2; r1_next = -xzm2; r2_next = da; r3_next = xym2; r4_next = xzp2;
            end
            qte_pkg::SEQ_XZY:
            begin
                three_next = 1'b1;
                r0_next = yzp2; r1_next = db; r2_next = -xym2; r3_next = xzp2; r4_next = da;
            end
            qte_pkg::SEQ_XZX:
            begin
                r0_next = xzm2; r1_next = xyp2; r2_next = da; r3_next = xzp2; r4_next = -xym2;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    qte_pkg::term_t r0_reg, r1_reg, r2_reg, r3_reg, r4_reg;
    logic three2_reg, ok2_reg, v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r0_reg     <= r0_next;
            r1_reg     <= r1_next;
            r2_reg     <= r2_next;
            r3_reg     <= r3_next;
            r4_reg     <= r4_next;
            three2_reg <= three_next;
            ok2_reg    <= ok_next;
        end
    end

    // stage 3: clamp the middle argument and scale its magnitude to Q30
    logic signed [63:0] a64, a_clip;
    logic        [63:0] mag, m64, m_sat;
    logic               clip_hi, clip_lo;
    logic [qte_pkg::ROOT_W-1:0] m_next;
    logic signed [qte_pkg::ACC_FRAC+1:0] aq_next;

    always_comb
    begin
        a64     = {{(64-qte_pkg::TERM_W){r2_reg[qte_pkg::TERM_W-1]}}, r2_reg};
        clip_hi = a64 > ONE;
        clip_lo = a64 < -ONE;
        a_clip  = clip_hi ? ONE : (clip_lo ? -ONE : a64);
        mag     = a_clip[63] ? 64'(-a_clip) : 64'(a_clip);
        m64     = (FB2 >= qte_pkg::ACC_FRAC) ? (mag >> SHR) : (mag << SHL);
        m_sat   = (m64 > ONE_Q30) ? ONE_Q30 : m64;
        m_next  = m_sat[qte_pkg::ROOT_W-1:0];
        aq_next = a_clip[63] ? -$signed({1'b0, m_next}) : $signed({1'b0, m_next});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            out_valid <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_m                  <= m_next;
            out_side.r0            <= r0_reg;
            out_side.r1            <= r1_reg;
            out_side.r3            <= r3_reg;
            out_side.r4            <= r4_reg;
            out_side.a             <= aq_next;
            out_side.flags.three   <= three2_reg;
            out_side.flags.seq_ok  <= ok2_reg;
            out_side.flags.clamped <= ok2_reg & (clip_hi | clip_lo);
        end
    end

endmodule
`default_nettype wire

@@ rtl/qte_isqrt.sv @@
`default_nettype none
module qte_isqrt (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         en,
    input  wire                         in_valid,
    input  wire logic [qte_pkg::ROOT_W-1:0] in_m,
    input  wire qte_pkg::side_t         in_side,
    output logic                        out_valid,
    output logic [qte_pkg::ROOT_W-1:0]  out_root,
    output qte_pkg::side_t              out_side
);

    localparam int STEPS = qte_pkg::ROOT_W;
    localparam int SW    = qte_pkg::SQ_W;
    localparam logic [SW-1:0] ONE_SQ = SW'(1) << (2 * qte_pkg::ACC_FRAC);

    logic [SW-1:0]  n_reg    [0:STEPS];
    logic [SW-1:0]  res_reg  [0:STEPS];
    qte_pkg::side_t side_reg [0:STEPS];
    logic           v_reg    [0:STEPS];
    logic [SW-1:0]  sq;

    // stage 0: radicand 1 - m^2 in Q60
    assign sq = in_m * in_m;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0]    <= ONE_SQ - sq;
            res_reg[0]  <= '0;
            side_reg[0] <= in_side;
        end
    end

    // one root bit per stage, highest bit first
    genvar k;
    generate
        for (k = 0; k < STEPS; k++)
        begin : g_step
            localparam logic [SW-1:0] BIT = SW'(1) << (2 * (STEPS - 1 - k));
            logic [SW-1:0] trial;
            logic          take;

            assign trial = res_reg[k] + BIT;
            assign take  = n_reg[k] >= trial;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k+1] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[k+1] <= v_reg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    n_reg[k+1]    <= take ? n_reg[k] - trial : n_reg[k];
                    res_reg[k+1]  <= take ? (res_reg[k] >> 1) + BIT : res_reg[k] >> 1;
                    side_reg[k+1] <= side_reg[k];
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[STEPS];
    assign out_root  = res_reg[STEPS][qte_pkg::ROOT_W-1:0];
    assign out_side  = side_reg[STEPS];

endmodule
`default_nettype wire

@@ rtl/qte_cordic.sv @@
`default_nettype none
module qte_cordic #(
    parameter int STAGES = 16
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               en,
    input  wire                               in_valid,
    input  wire qte_pkg::term_t               in_y,
    input  wire qte_pkg::term_t               in_x,
    input  wire qte_pkg::flags_t              in_sb,
    output logic                              out_valid,
    output logic signed [qte_pkg::ACC_W-1:0]  out_z,
    output qte_pkg::flags_t                   out_sb
);

    localparam int CW = qte_pkg::CORDIC_W;
    localparam int AW = qte_pkg::ACC_W;

    logic signed [CW-1:0] x_reg    [0:STAGES];
    logic signed [CW-1:0] y_reg    [0:STAGES];
    logic signed [AW-1:0] z_reg    [0:STAGES];
    logic                 zero_reg [0:STAGES];
    qte_pkg::flags_t      sb_reg   [0:STAGES];
    logic                 v_reg    [0:STAGES];

    // prescale and fold the left half-plane onto the right
    logic signed [CW-1:0] xs, ys, x0, y0;
    logic signed [AW-1:0] z0;

    always_comb
    begin
        xs = {{(CW-qte_pkg::TERM_W){in_x[qte_pkg::TERM_W-1]}}, in_x} <<< qte_pkg::PRESCALE_SHIFT;
        ys = {{(CW-qte_pkg::TERM_W){in_y[qte_pkg::TERM_W-1]}}, in_y} <<< qte_pkg::PRESCALE_SHIFT;
        x0 = xs;
        y0 = ys;
        z0 = '0;
        if (xs < 0)
        begin
            if (ys >= 0)
            begin
                x0 = ys;
                y0 = -xs;
                z0 = qte_pkg::HALF_PI_Q30;
            end
            else
            begin
                x0 = -ys;
                y0 = xs;
                z0 = -qte_pkg::HALF_PI_Q30;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x0;
            y_reg[0]    <= y0;
            z_reg[0]    <= z0;
            zero_reg[0] <= (in_x == '0) && (in_y == '0);
            sb_reg[0]   <= in_sb;
        end
    end

    // vectoring micro-rotations, one per stage
    genvar i;
    generate
        for (i = 0; i < STAGES; i++)
        begin : g_rot
            localparam logic signed [AW-1:0] ATAN = AW'(qte_pkg::ATAN_TAB[i]);
            logic signed [CW-1:0] dx, dy;
            logic                 up;

            assign dx = y_reg[i] >>> i;
            assign dy = x_reg[i] >>> i;
            assign up = y_reg[i] >= 0;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[i+1] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[i+1] <= v_reg[i];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[i+1]    <= up ? x_reg[i] + dx : x_reg[i] - dx;
                    y_reg[i+1]    <= up ? y_reg[i] - dy : y_reg[i] + dy;
                    z_reg[i+1]    <= up ? z_reg[i] + ATAN : z_reg[i] - ATAN;
                    zero_reg[i+1] <= zero_reg[i];
                    sb_reg[i+1]   <= sb_reg[i];
                end
            end
        end
    endgenerate

    // hold the angle within [-pi, pi]; both operands zero gives zero
    logic signed [AW-1:0] zf;

    always_comb
    begin
        zf = z_reg[STAGES];
        if (zf > qte_pkg::PI_Q30)
        begin
            zf = qte_pkg::PI_Q30;
        end
        if (zf < -qte_pkg::PI_Q30)
        begin
            zf = -qte_pkg::PI_Q30;
        end
        if (zero_reg[STAGES])
        begin
            zf = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            out_valid <= v_reg[STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_z  <= zf;
            out_sb <= sb_reg[STAGES];
        end
    end

endmodule
`default_nettype wire
